// ===== sv/bpru_pkg.sv =====
package bpru_pkg;

  // Field and counter widths
  localparam int BYTE_W    = 8;
  localparam int BPP_W     = 3;
  localparam int DIM_W     = 13;
  localparam int POS_W     = 15;
  localparam int ADDR_W    = 26;
  localparam int IDX_W     = 2;
  localparam int MAX_PIX   = 4;
  localparam int HELD_N    = MAX_PIX - 1;
  localparam int CFG_IDX_W = 2;

  // Pixel queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Image size limits
  localparam logic [DIM_W-1:0] MAX_WIDTH  = 13'd4096;
  localparam logic [DIM_W-1:0] MAX_HEIGHT = 13'd4096;

  // Register reset values
  localparam logic [BPP_W-1:0] BPP_RESET    = 3'd3;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BPP    = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  // Derived configuration handed to the front end
  typedef struct packed {
    logic             ok;        // pixel size and dimensions usable
    logic             busy;      // derived values being recomputed
    logic             rebase;    // reload the row base address this cycle
    logic [BPP_W-1:0] bpp;
    logic [DIM_W-1:0] height;    // saturated height
    logic [POS_W-1:0] row_size;  // data bytes per row
    logic [POS_W-1:0] row_len;   // row size incl. padding
  } cfg_t;

  // One finished pixel, bytes already in output order
  typedef struct packed {
    logic [ADDR_W-1:0]                  addr;
    logic [IDX_W-1:0]                   last_k;
    logic [MAX_PIX-1:0][BYTE_W-1:0]     data;
  } pix_entry_t;

endpackage

// ===== sv/bpru_cfg.sv =====
module bpru_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpru_pkg::DIM_W-1:0]    cfg_data,
  output bpru_pkg::cfg_t                cfg
);
  import bpru_pkg::*;

  logic [BPP_W-1:0]       bpp_r;
  logic [DIM_W-1:0]       width_r;
  logic [DIM_W-1:0]       height_r;
  logic [DIM_W-1:0]       h_sat_r;
  logic [POS_W-1:0]       row_size_r;
  logic [POS_W-1:0]       row_len_r;
  logic                   ok_r;
  logic [1:0]             recalc_r;

  logic [DIM_W-1:0]       w_sat;
  logic [DIM_W-1:0]       h_sat_nxt;
  logic [DIM_W+BPP_W-1:0] size_prod;
  logic [POS_W-1:0]       row_size_nxt;
  logic [POS_W:0]         len_sum;
  logic [POS_W-1:0]       row_len_nxt;
  logic                   ok_nxt;
  logic                   wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= BPP_RESET;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (wr) begin
      if (cfg_index == REG_BPP)    bpp_r    <= cfg_data[BPP_W-1:0];
      if (cfg_index == REG_WIDTH)  width_r  <= cfg_data;
      if (cfg_index == REG_HEIGHT) height_r <= cfg_data;
    end
  end

  // Saturation and row geometry
  always_comb begin
    w_sat        = (width_r > MAX_WIDTH) ? MAX_WIDTH : width_r;
    h_sat_nxt    = (height_r > MAX_HEIGHT) ? MAX_HEIGHT : height_r;
    size_prod    = w_sat * bpp_r;
    row_size_nxt = size_prod[POS_W-1:0];
    len_sum      = {1'b0, row_size_nxt} + (POS_W+1)'(3);
    row_len_nxt  = {len_sum[POS_W-1:2], 2'b00};
    ok_nxt       = (bpp_r >= BPP_W'(1)) && (bpp_r <= BPP_W'(MAX_PIX)) &&
                   (width_r != '0) && (height_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_sat_r    <= HEIGHT_RESET;
      row_size_r <= POS_W'(3);
      row_len_r  <= POS_W'(4);
      ok_r       <= 1'b1;
    end else begin
      h_sat_r    <= h_sat_nxt;
      row_size_r <= row_size_nxt;
      row_len_r  <= row_len_nxt;
      ok_r       <= ok_nxt;
    end
  end

  // Recompute after any write: geometry, then base address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recalc_r <= 2'd0;
    end else if (wr) begin
      recalc_r <= 2'd2;
    end else if (recalc_r != 2'd0) begin
      recalc_r <= recalc_r - 2'd1;
    end
  end

  always_comb begin
    cfg.ok       = ok_r;
    cfg.busy     = (recalc_r != 2'd0);
    cfg.rebase   = (recalc_r == 2'd1);
    cfg.bpp      = bpp_r;
    cfg.height   = h_sat_r;
    cfg.row_size = row_size_r;
    cfg.row_len  = row_len_r;
  end

endmodule

// ===== sv/bpru_front.sv =====
module bpru_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bpru_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bpru_pkg::BYTE_W-1:0] in_pixel_byte,
  input  logic                        q_full,
  output logic                        push,
  output bpru_pkg::pix_entry_t        push_entry
);
  import bpru_pkg::*;

  logic [POS_W-1:0]  pos_r;
  logic [DIM_W-1:0]  rows_done_r;
  logic [IDX_W-1:0]  idx_r;
  logic [BYTE_W-1:0] held_r [HELD_N];
  logic [ADDR_W-1:0] base_r;

  logic                      acc;
  logic                      active;
  logic                      in_data;
  logic                      pix_done;
  logic [POS_W:0]            pos_inc;
  logic                      row_end;
  logic [DIM_W-1:0]          diff;
  logic [DIM_W+POS_W-1:0]    base_prod;
  logic [BYTE_W-1:0]         view [MAX_PIX];
  logic [IDX_W-1:0]          src;

  assign in_ready = !q_full && !cfg.busy;
  assign acc      = in_valid && in_ready;

  // Classify the byte: data or padding, mid-pixel or pixel end
  always_comb begin
    active    = cfg.ok && (rows_done_r < cfg.height);
    in_data   = (pos_r < cfg.row_size);
    pix_done  = (({1'b0, idx_r} + (IDX_W+1)'(1)) >= cfg.bpp);
    pos_inc   = {1'b0, pos_r} + (POS_W+1)'(1);
    row_end   = (pos_inc >= {1'b0, cfg.row_len});
    diff      = cfg.height - DIM_W'(1) - rows_done_r;
    base_prod = diff * cfg.row_size;
  end

  // Pixel bytes in reversed order, current byte first
  always_comb begin
    for (int j = 0; j < HELD_N; j++) begin
      view[j] = (IDX_W'(j) == idx_r) ? in_pixel_byte : held_r[j];
    end
    view[MAX_PIX-1] = in_pixel_byte;
    push_entry.addr   = base_r + ADDR_W'(pos_r) - ADDR_W'(idx_r);
    push_entry.last_k = idx_r;
    for (int k = 0; k < MAX_PIX; k++) begin
      src = idx_r - IDX_W'(k);
      push_entry.data[k] = view[src];
    end
  end

  assign push = acc && active && in_data && pix_done;

  // Row and pixel counters, row base address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      rows_done_r <= '0;
      idx_r       <= '0;
      base_r      <= '0;
    end else if (cfg.rebase) begin
      base_r <= base_prod[ADDR_W-1:0];
    end else if (acc && active) begin
      if (in_data) begin
        if (pix_done) idx_r <= '0;
        else          idx_r <= idx_r + IDX_W'(1);
      end
      if (row_end) begin
        pos_r       <= '0;
        idx_r       <= '0;
        rows_done_r <= rows_done_r + DIM_W'(1);
        base_r      <= base_r - ADDR_W'(cfg.row_size);
      end else begin
        pos_r <= pos_inc[POS_W-1:0];
      end
    end
  end

  // Held bytes of the pixel in progress
  always_ff @(posedge clk) begin
    if (acc && active && in_data && !pix_done && (idx_r != IDX_W'(HELD_N))) begin
      held_r[idx_r] <= in_pixel_byte;
    end
  end

endmodule

// ===== sv/bpru_queue.sv =====
module bpru_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  bpru_pkg::pix_entry_t push_entry,
  output logic                 full,
  input  logic                 pop,
  output bpru_pkg::pix_entry_t head,
  output logic                 empty
);
  import bpru_pkg::*;

  pix_entry_t         slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  assign full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      if (push && !pop)      count_r <= count_r + Q_CNT_W'(1);
      else if (pop && !push) count_r <= count_r - Q_CNT_W'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("pixel queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pixel queue pop while empty");
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
      (push && !pop) |=> (count_r == $past(count_r) + Q_CNT_W'(1)))
    else $error("pixel queue level did not follow push");

endmodule

// ===== sv/bpru_back.sv =====
module bpru_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bpru_pkg::pix_entry_t        head,
  input  logic                        empty,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bpru_pkg::ADDR_W-1:0] out_dest_address,
  output logic [bpru_pkg::BYTE_W-1:0] out_data_byte,
  output logic                        out_last_of_run
);
  import bpru_pkg::*;

  logic [IDX_W-1:0]  k_r;
  logic              out_valid_r;
  logic [ADDR_W-1:0] addr_r;
  logic [BYTE_W-1:0] data_r;
  logic              last_r;

  logic load;
  logic last_k;

  // Load the next byte of the head pixel when the output register frees up
  assign load   = !empty && (!out_valid_r || out_ready);
  assign last_k = (k_r == head.last_k);
  assign pop    = load && last_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      k_r         <= last_k ? '0 : k_r + IDX_W'(1);
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      addr_r <= head.addr + ADDR_W'(k_r);
      data_r <= head.data[k_r];
      last_r <= last_k;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dest_address = addr_r;
  assign out_data_byte    = data_r;
  assign out_last_of_run  = last_r;

  a_k_in_pixel: assert property (@(posedge clk) disable iff (!rst_n)
      !empty |-> (k_r <= head.last_k))
    else $error("byte counter past end of pixel");

endmodule

// ===== sv/bmp_pixel_row_unpacker_unit.sv =====
// BMP pixel array row unpacker.
// Input channel (in_valid/in_ready/in_pixel_byte): the stored pixel array,
// one byte per transaction, from the first pixel byte on, padding included.
// Output channel (out_valid/out_ready/out_*): one transaction per destination
// byte; a pixel's bytes come out in reversed order at top-down addresses,
// out_last_of_run marking the pixel's final byte. Padding and bytes after the
// last row produce nothing.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 pixel size
// in bytes, 1 width, 2 height. Write only while the block is idle; input is
// held off after each write while row geometry and the row base address are
// recomputed. Throughput: one input byte and one output byte per cycle unless
// in_ready or out_ready is low. A pixel's first byte passes through the pixel
// queue and the output register after its last input byte is taken.
// A four-entry pixel queue separates the byte counters from the output
// sequencer; when the receiver stalls, the queue fills and in_ready drops.
// Reset: counters and queue clear, registers return to 3 bytes, 1 x 1 image.
module bmp_pixel_row_unpacker_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bpru_pkg::BYTE_W-1:0]    in_pixel_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bpru_pkg::ADDR_W-1:0]    out_dest_address,
  output logic [bpru_pkg::BYTE_W-1:0]    out_data_byte,
  output logic                           out_last_of_run,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpru_pkg::DIM_W-1:0]     cfg_data
);
  import bpru_pkg::*;

  cfg_t       cfg;
  logic       push;
  pix_entry_t push_entry;
  logic       q_full;
  logic       pop;
  pix_entry_t head;
  logic       q_empty;

  bpru_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpru_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_byte (in_pixel_byte),
    .q_full        (q_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  bpru_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  bpru_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .empty            (q_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_dest_address (out_dest_address),
    .out_data_byte    (out_data_byte),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
